// File: sv/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Types and register codes shared by the weighted matrix sum block.
// ----------------------------------------------------------------------------
package wms_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_W      = 4;

    localparam logic [1:0] REG_ROWS    = 2'd0;
    localparam logic [1:0] REG_COLS    = 2'd1;
    localparam logic [1:0] REG_REGIMES = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [2:0]         regime;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] sum_value;
        logic               saturated;
        logic               error;
        logic               last_out;
    } out_item_t;

endpackage

// File: sv/wms_in_if.sv
// ----------------------------------------------------------------------------
// wms_in_if
// Valid/ready channel that carries input items.
// ----------------------------------------------------------------------------
interface wms_in_if;
    logic               valid;
    logic               ready;
    wms_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/wms_out_if.sv
// ----------------------------------------------------------------------------
// wms_out_if
// Valid/ready channel that carries result items.
// ----------------------------------------------------------------------------
interface wms_out_if;
    logic               valid;
    logic               ready;
    wms_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wms_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/weighted_matrix_sum.sv
// ----------------------------------------------------------------------------
// weighted_matrix_sum
// Loads regime matrices, collects one weight per regime and emits the
// saturated Q16.16 weighted sum of the matrices, element by element.
// ----------------------------------------------------------------------------
// Load items and weight items without the last flag are accepted
// whenever the block is idle. A weight item with last set starts a sum
// pass during which no item is accepted: for every element and regime the
// matrix store is read (S_RD, S_LD) and the product is built by a
// bit-serial shift-add multiplier, one bit of the V-bit weight per cycle,
// V being the value width (32 by default); S_FIN then emits the sum. A
// weight count mismatch gives one error item instead. The matrix store has
// no reset; every entry used by a sum has to be loaded first.
module weighted_matrix_sum #(
    parameter int MAX_DIM     = 8,
    parameter int MAX_REGIMES = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wms_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wms_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wms_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    wms_in_if.sink                        item_ch,
    wms_out_if.source                     result_ch
);

    import wms_pkg::*;

    localparam int VAL_W    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ACC_W    = 2 * VAL_W + 4;
    localparam int RES_W    = ACC_W - 16;
    localparam int K_LIMIT  = (MAX_REGIMES < 8) ? MAX_REGIMES : 8;
    localparam int DEPTH    = MAX_REGIMES * MAX_DIM * MAX_DIM;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(VAL_W);

    localparam logic signed [RES_W-1:0] SAT_MAX =
        {{(RES_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN = ~SAT_MAX;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_LD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [REG_W-1:0] rows_reg, cols_reg, regimes_reg;
    logic [3:0]       seen_reg;
    logic [2:0]       state_reg;
    logic [3:0]       r_reg, c_reg, k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [ACC_W-1:0] acc_reg, mc_reg;
    logic [VAL_W-1:0] mult_reg;
    logic [VAL_W-1:0] weights_reg [8];
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [3:0]       nr, nc, nk, seen_inc;
    logic             cfg_wr, accept, out_free, emit;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    logic signed [ACC_W-1:0] addend, rnd;
    logic signed [RES_W-1:0] res, sat_res;
    logic             sat_hit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS:    prdata = 32'(rows_reg);
            REG_COLS:    prdata = 32'(cols_reg);
            REG_REGIMES: prdata = 32'(regimes_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= 4'd2;
            cols_reg    <= 4'd2;
            regimes_reg <= 4'd2;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS:    rows_reg    <= pwdata[REG_W-1:0];
                REG_COLS:    cols_reg    <= pwdata[REG_W-1:0];
                REG_REGIMES: regimes_reg <= pwdata[REG_W-1:0];
                default:     ;
            endcase
        end
    end

    // clamp the sizes to what the store holds
    always_comb
    begin
        nr = (rows_reg == 4'd0) ? 4'd1 :
             (rows_reg > 4'(MAX_DIM)) ? 4'(MAX_DIM) : rows_reg;
        nc = (cols_reg == 4'd0) ? 4'd1 :
             (cols_reg > 4'(MAX_DIM)) ? 4'(MAX_DIM) : cols_reg;
        nk = (regimes_reg == 4'd0) ? 4'd1 :
             (regimes_reg > 4'(K_LIMIT)) ? 4'(K_LIMIT) : regimes_reg;
    end

    assign item_ch.ready = (state_reg == S_IDLE);
    assign accept        = item_ch.valid && item_ch.ready;
    assign out_free      = !out_valid_reg || result_ch.ready;
    assign emit          = out_free && ((state_reg == S_FIN) || (state_reg == S_ERR));
    assign seen_inc      = (seen_reg == 4'd15) ? seen_reg : seen_reg + 4'd1;

    assign ram_we = accept && (item_ch.data.kind == KIND_LOAD)
                    && (32'(item_ch.data.regime) < MAX_REGIMES)
                    && (32'(item_ch.data.row) < MAX_DIM)
                    && (32'(item_ch.data.col) < MAX_DIM);
    assign ram_waddr = AW'(32'(item_ch.data.regime) * MAX_DIM * MAX_DIM
                           + 32'(item_ch.data.row) * MAX_DIM
                           + 32'(item_ch.data.col));
    assign ram_raddr = AW'(32'(k_reg) * MAX_DIM * MAX_DIM
                           + 32'(r_reg) * MAX_DIM + 32'(c_reg));

    wms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(item_ch.data.value[VAL_W-1:0]),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept && item_ch.data.kind == KIND_WEIGHT)
        begin
            weights_reg[item_ch.data.regime] <= item_ch.data.value[VAL_W-1:0];
        end
    end

    // the weight sign bit carries negative weight
    always_comb
    begin
        if (!mult_reg[0])
        begin
            addend = '0;
        end
        else if (cnt_reg == CNT_W'(VAL_W-1))
        begin
            addend = -mc_reg;
        end
        else
        begin
            addend = mc_reg;
        end
    end

    assign rnd     = acc_reg + ACC_W'(32'h8000);
    assign res     = rnd[ACC_W-1:16];
    assign sat_hit = (res > SAT_MAX) || (res < SAT_MIN);
    assign sat_res = (res > SAT_MAX) ? SAT_MAX : (res < SAT_MIN) ? SAT_MIN : res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && item_ch.data.kind == KIND_WEIGHT)
                    begin
                        if (item_ch.data.last)
                        begin
                            seen_reg <= '0;
                            r_reg    <= '0;
                            c_reg    <= '0;
                            k_reg    <= '0;
                            acc_reg  <= '0;
                            state_reg <= (seen_inc == nk) ? S_RD : S_ERR;
                        end
                        else
                        begin
                            seen_reg <= seen_inc;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LD;
                end
                S_LD:
                begin
                    mc_reg    <= {{(ACC_W-VAL_W){ram_rdata[VAL_W-1]}}, ram_rdata};
                    mult_reg  <= weights_reg[k_reg[2:0]];
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    acc_reg  <= acc_reg + addend;
                    mc_reg   <= mc_reg <<< 1;
                    mult_reg <= mult_reg >> 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(VAL_W-1))
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= (k_reg + 4'd1 < nk) ? S_RD : S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_item_reg.out_row   <= r_reg[2:0];
                        out_item_reg.out_col   <= c_reg[2:0];
                        out_item_reg.sum_value <= 32'(sat_res);
                        out_item_reg.saturated <= sat_hit;
                        out_item_reg.error     <= 1'b0;
                        out_item_reg.last_out  <= (r_reg + 4'd1 == nr) && (c_reg + 4'd1 == nc);
                        acc_reg <= '0;
                        k_reg   <= '0;
                        if (c_reg + 4'd1 < nc)
                        begin
                            c_reg     <= c_reg + 4'd1;
                            state_reg <= S_RD;
                        end
                        else if (r_reg + 4'd1 < nr)
                        begin
                            c_reg     <= '0;
                            r_reg     <= r_reg + 4'd1;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_item_reg.out_row   <= '0;
                        out_item_reg.out_col   <= '0;
                        out_item_reg.sum_value <= '0;
                        out_item_reg.saturated <= 1'b0;
                        out_item_reg.error     <= 1'b1;
                        out_item_reg.last_out  <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_item_reg;

endmodule

// File: test/tb_weighted_matrix_sum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_matrix_sum
// Self-checking bench for the weighted matrix sum block. The whole matrix
// store is filled first. A short table of directed items follows; it opens
// by filling every weight slot. Random items over several register settings
// come last. A predictor in the bench tracks matrices, weights and the
// weight count. It queues the sums (or the error item) that each accepted
// item causes. The queue is checked against the result channel.
// ----------------------------------------------------------------------------
module tb_weighted_matrix_sum;
    import wms_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        in_item_t item;
        bit       typed;
    } table_row_t;

    typedef struct {
        logic [3:0] rows;
        logic [3:0] cols;
        logic [3:0] regimes;
        int         n_items;
    } phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wms_in_if  item_ch ();
    wms_out_if result_ch ();

    weighted_matrix_sum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .item_ch   (item_ch),
        .result_ch (result_ch)
    );

    // shadow state of the block
    logic signed [31:0] matrix_shadow [0:511];
    logic signed [31:0] weight_shadow [0:7];
    logic [3:0]         weight_count = '0;
    logic [3:0]         cfg_rows = 4'd2;
    logic [3:0]         cfg_cols = 4'd2;
    logic [3:0]         cfg_regimes = 4'd2;

    out_item_t pending_sums [$];
    out_item_t error_result;
    int        fails = 0;
    int        cycles = 0;
    int        idle_mode = 0;
    int        random_sent = 0;

    initial item_ch.valid = 1'b0;
    initial item_ch.data = '0;
    initial result_ch.ready = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int clamp_dim(logic [3:0] v, int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // updates the shadow state and queues the results this item causes
    function automatic void predict_sums(in_item_t it, ref out_item_t res[$]);
        int                 nr;
        int                 nc;
        int                 nk;
        logic signed [79:0] acc;
        logic signed [79:0] rounded;
        out_item_t          o;
        if (it.kind == KIND_LOAD)
        begin
            matrix_shadow[{it.regime, it.row, it.col}] = it.value;
            return;
        end
        weight_shadow[it.regime] = it.value;
        if (weight_count < 4'd15)
            weight_count = weight_count + 4'd1;
        if (!it.last)
            return;
        nr = clamp_dim(cfg_rows, 8);
        nc = clamp_dim(cfg_cols, 8);
        nk = clamp_dim(cfg_regimes, 8);
        if (weight_count != nk)
        begin
            weight_count = '0;
            res.push_back(error_result);
            return;
        end
        weight_count = '0;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                    acc += matrix_shadow[k * 64 + r * 8 + c] * weight_shadow[k];
                // round half up, then clip to the 32-bit range
                rounded = (acc + 80'sd32768) >>> 16;
                o = '0;
                o.out_row = r[2:0];
                o.out_col = c[2:0];
                if (rounded > 80'sd2147483647)
                begin
                    o.sum_value = 32'h7FFFFFFF;
                    o.saturated = 1'b1;
                end
                else if (rounded < -80'sd2147483648)
                begin
                    o.sum_value = 32'h80000000;
                    o.saturated = 1'b1;
                end
                else
                    o.sum_value = rounded[31:0];
                o.last_out = (r == nr - 1) && (c == nc - 1);
                res.push_back(o);
            end
        end
    endfunction

    function automatic in_item_t make_item(logic kind, int regime, int row, int col,
                                           logic [31:0] value, logic last);
        in_item_t it;
        it.kind = kind;
        it.regime = regime[2:0];
        it.row = row[2:0];
        it.col = col[2:0];
        it.value = value;
        it.last = last;
        return it;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1 << 18) - (1 << 17);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit field_ok(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // result side: random stall and compare against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t exp_r;
        out_item_t act_r;
        bit        ok;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            act_r = result_ch.data;
            if (pending_sums.size() == 0)
            begin
                $error("result item with nothing expected");
                fails++;
            end
            else
            begin
                exp_r = pending_sums.pop_front();
                ok = field_ok("out_row", exp_r.out_row, act_r.out_row);
                ok &= field_ok("out_col", exp_r.out_col, act_r.out_col);
                ok &= field_ok("sum_value", exp_r.sum_value, act_r.sum_value);
                ok &= field_ok("saturated", exp_r.saturated, act_r.saturated);
                ok &= field_ok("error", exp_r.error, act_r.error);
                ok &= field_ok("last_out", exp_r.last_out, act_r.last_out);
                if (!ok)
                    fails++;
            end
        end
        case (idle_mode)
            0: result_ch.ready <= ($urandom_range(0, 99) >= 52);
            1: result_ch.ready <= ($urandom_range(0, 99) >= 18);
            default: result_ch.ready <= 1'b1;
        endcase
    end

    task automatic send_item(in_item_t it, bit typed);
        int        pct;
        out_item_t dummy [$];
        pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 52 : 0;
        if ($urandom_range(0, 99) < pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < pct);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (typed)
        begin
            predict_sums(it, dummy);
            pending_sums.push_back(error_result);
        end
        else
            predict_sums(it, pending_sums);
    endtask

    task automatic send_random(in_item_t it);
        send_item(it, 1'b0);
        random_sent++;
        idle_mode = (random_sent < 60) ? 0 : (random_sent < 120) ? 1 : 2;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [3:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {28'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ROWS:    cfg_rows = v;
            REG_COLS:    cfg_cols = v;
            REG_REGIMES: cfg_regimes = v;
            default:     ;
        endcase
    endtask

    initial
    begin
        table_row_t directed [$];
        phase_t     phases [$];
        phase_t     ph;
        int         sent;
        int         nk;
        int         cnt;
        int         pick;

        error_result = '0;
        error_result.error = 1'b1;
        error_result.last_out = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole matrix store so no sum reads an unwritten entry
        for (int i = 0; i < 512; i++)
            send_item(make_item(KIND_LOAD, i / 64, (i / 8) % 8, i % 8,
                                $urandom, 1'($urandom_range(0, 1))), 1'b0);

        // reset setting is 2x2 over 2 regimes; eight weights give an error
        for (int k = 0; k < 8; k++)
            directed.push_back('{make_item(KIND_WEIGHT, k, $urandom, $urandom,
                                           random_value(), k == 7), k == 7});
        // positive overflow at (0,0), negative at (0,1)
        directed.push_back('{make_item(KIND_LOAD, 0, 0, 0, 32'h7FFFFFFF, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_LOAD, 1, 0, 0, 32'h7FFFFFFF, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_LOAD, 0, 0, 1, 32'h80000000, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_LOAD, 1, 0, 1, 32'h80000000, 1'b1), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 0, 7, 7, 32'h7FFFFFFF, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 1, 0, 0, 32'h7FFFFFFF, 1'b1), 1'b0});
        // both weights most negative
        directed.push_back('{make_item(KIND_WEIGHT, 0, 0, 0, 32'h80000000, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 1, 0, 0, 32'h80000000, 1'b1), 1'b0});
        // too few weights
        directed.push_back('{make_item(KIND_WEIGHT, 0, 0, 0, 32'h00010000, 1'b1), 1'b1});
        // zero weights, a load in between with its last bit set
        directed.push_back('{make_item(KIND_WEIGHT, 0, 0, 0, 32'h0, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_LOAD, 1, 1, 1, 32'hFFFF8000, 1'b1), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 1, 0, 0, 32'h0, 1'b1), 1'b0});
        // unit and minus-half weights, rounding on ties
        directed.push_back('{make_item(KIND_LOAD, 0, 1, 0, 32'h00000001, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 0, 0, 0, 32'h00010000, 1'b0), 1'b0});
        directed.push_back('{make_item(KIND_WEIGHT, 1, 0, 0, 32'hFFFF8000, 1'b1), 1'b0});
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed);

        phases.push_back('{4'd1, 4'd1, 4'd1, 30});
        phases.push_back('{4'd8, 4'd8, 4'd8, 10});
        phases.push_back('{4'd0, 4'd0, 4'd0, 25});
        phases.push_back('{4'd15, 4'd15, 4'd15, 9});
        phases.push_back('{4'd3, 4'd5, 4'd4, 35});
        phases.push_back('{4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
                           4'($urandom_range(1, 4)), 40});
        phases.push_back('{4'd2, 4'd8, 4'd1, 30});

        foreach (phases[p])
        begin
            ph = phases[p];
            drain();
            cfg_write(REG_ROWS, ph.rows);
            cfg_write(REG_COLS, ph.cols);
            cfg_write(REG_REGIMES, ph.regimes);
            nk = clamp_dim(ph.regimes, 8);
            sent = random_sent;
            while (random_sent - sent < ph.n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    send_random(make_item(KIND_LOAD, $urandom, $urandom, $urandom,
                                          random_value(), 1'($urandom_range(0, 1))));
                else if (pick < 85)
                begin
                    // well-formed weight row
                    for (int k = 0; k < nk; k++)
                        send_random(make_item(KIND_WEIGHT, k, $urandom, $urandom,
                                              random_value(), k == nk - 1));
                end
                else
                begin
                    // broken row, may run the count up to its ceiling
                    cnt = $urandom_range(1, 17);
                    for (int k = 0; k < cnt; k++)
                        send_random(make_item(KIND_WEIGHT, $urandom, $urandom,
                                              $urandom, random_value(), k == cnt - 1));
                end
            end
        end

        drain();
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
sv/wms_pkg.sv
sv/wms_in_if.sv
sv/wms_out_if.sv
sv/wms_ram.sv
sv/weighted_matrix_sum.sv
test/tb_weighted_matrix_sum.sv
